// ===== hw/rtl/hsx_pkg.sv =====
package hsx_pkg;

	localparam int ADDR_BYTES = 16;
	localparam int ADDR_BITS  = 128;
	localparam int NIB_SLOTS  = 2 * ADDR_BYTES;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE_HIGH = 2'd0;
	localparam logic [1:0] REG_BASE_LOW  = 2'd1;
	localparam logic [1:0] REG_PREFIX    = 2'd2;

	localparam logic [3:0] PREFIX_RESET = 4'd8;

	// Bytes of the two-byte UTF-8 umlauts.
	localparam logic [7:0] UTF_LEAD   = 8'd195;
	localparam logic [7:0] UTF_A_LOW  = 8'd164;
	localparam logic [7:0] UTF_A_UP   = 8'd132;
	localparam logic [7:0] UTF_O_LOW  = 8'd182;
	localparam logic [7:0] UTF_O_UP   = 8'd150;
	localparam logic [7:0] UTF_U_LOW  = 8'd188;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_P,
		PH_L,
		PH_LE,
		PH_LEE,
		PH_U
	} phase_t;

	// Up to four nibbles, oldest in the highest used slot.
	typedef struct packed {
		logic [15:0] nibs;
		logic [2:0]  cnt;
	} nib_list_t;

	typedef struct packed {
		nib_list_t list;
		phase_t    phase;
	} scan_res_t;

	function automatic nib_list_t push(nib_list_t l, logic [3:0] v);
		nib_list_t r;
		r.nibs = {l.nibs[11:0], v};
		r.cnt  = l.cnt + 3'd1;
		return r;
	endfunction

	// Bit 4 flags a mapped character, bits 3:0 carry its nibble.
	function automatic logic [4:0] letter(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "1" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end else begin
			case (c)
				"0", "o": r = {1'b1, 4'h0};
				"i", "j": r = {1'b1, 4'h1};
				"g":      r = {1'b1, 4'h9};
				"q":      r = {1'b1, 4'h6};
				"k", "z": r = {1'b1, 4'hC};
				"s":      r = {1'b1, 4'h5};
				"r":      r = {1'b1, 4'h7};
				"t":      r = {1'b1, 4'hD};
				default:  r = 5'd0;
			endcase
		end
		return r;
	endfunction

	// Scan of a byte with no lookahead pending.
	function automatic scan_res_t scan_idle(logic [7:0] b, nib_list_t l);
		scan_res_t  r;
		logic [7:0] c;
		logic [4:0] m;
		c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		m = letter(c);
		r.list  = l;
		r.phase = PH_IDLE;
		if (c == "p") begin
			r.phase = PH_P;
		end else if (c == "l") begin
			r.phase = PH_L;
		end else if (b == UTF_LEAD) begin
			r.phase = PH_U;
		end else if (m[4]) begin
			r.list = push(l, m[3:0]);
		end
		return r;
	endfunction

	// Suffix capacity in nibbles for a given prefix length.
	function automatic logic [5:0] suffix_cap(logic [3:0] prefix);
		logic [5:0] r;
		r = 6'd0;
		if (int'(prefix) < ADDR_BYTES) begin
			r = 6'(2 * (ADDR_BYTES - int'(prefix)));
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hsx_decode.sv =====
module hsx_decode (
	input  hsx_pkg::phase_t    phase,
	input  logic [7:0]         char_byte,
	input  logic               last_byte,
	input  logic [5:0]         count,
	input  logic [5:0]         cap,
	output hsx_pkg::scan_res_t res
);

	logic leet_fits;

	assign leet_fits = ({1'b0, count} + 7'd4) <= {1'b0, cap};

	always_comb begin
		res.list  = '0;
		res.phase = hsx_pkg::PH_IDLE;
		case (phase)
			hsx_pkg::PH_P: begin
				if (char_byte == "h" || char_byte == "H") begin
					res.list = hsx_pkg::push(res.list, 4'hF);
				end else begin
					res.list = hsx_pkg::push(res.list, 4'hB);
					res = hsx_pkg::scan_idle(char_byte, res.list);
				end
			end
			hsx_pkg::PH_L: begin
				if (char_byte == "e") begin
					res.phase = hsx_pkg::PH_LE;
				end else begin
					res.list = hsx_pkg::push(res.list, 4'h1);
					res = hsx_pkg::scan_idle(char_byte, res.list);
				end
			end
			hsx_pkg::PH_LE: begin
				if (char_byte == "e") begin
					res.phase = hsx_pkg::PH_LEE;
				end else begin
					res.list = hsx_pkg::push(res.list, 4'h1);
					res.list = hsx_pkg::push(res.list, 4'hE);
					res = hsx_pkg::scan_idle(char_byte, res.list);
				end
			end
			hsx_pkg::PH_LEE: begin
				// The whole word is written only when all four nibbles fit.
				if (char_byte == "t" && leet_fits) begin
					res.list = hsx_pkg::push(res.list, 4'h1);
					res.list = hsx_pkg::push(res.list, 4'h3);
					res.list = hsx_pkg::push(res.list, 4'h3);
					res.list = hsx_pkg::push(res.list, 4'h7);
				end else begin
					res.list = hsx_pkg::push(res.list, 4'h1);
					res.list = hsx_pkg::push(res.list, 4'hE);
					res.list = hsx_pkg::push(res.list, 4'hE);
					res = hsx_pkg::scan_idle(char_byte, res.list);
				end
			end
			hsx_pkg::PH_U: begin
				if (char_byte == hsx_pkg::UTF_A_LOW || char_byte == hsx_pkg::UTF_A_UP) begin
					res.list = hsx_pkg::push(res.list, 4'hA);
					res.list = hsx_pkg::push(res.list, 4'hE);
				end else if (char_byte == hsx_pkg::UTF_O_LOW || char_byte == hsx_pkg::UTF_O_UP
						|| char_byte == hsx_pkg::UTF_U_LOW) begin
					res.list = hsx_pkg::push(res.list, 4'h0);
					res.list = hsx_pkg::push(res.list, 4'hE);
				end else begin
					res = hsx_pkg::scan_idle(char_byte, res.list);
				end
			end
			default: begin
				res = hsx_pkg::scan_idle(char_byte, res.list);
			end
		endcase

		// The last byte flushes any pending lookahead.
		if (last_byte) begin
			case (res.phase)
				hsx_pkg::PH_P: res.list = hsx_pkg::push(res.list, 4'hB);
				hsx_pkg::PH_L: res.list = hsx_pkg::push(res.list, 4'h1);
				hsx_pkg::PH_LE: begin
					res.list = hsx_pkg::push(res.list, 4'h1);
					res.list = hsx_pkg::push(res.list, 4'hE);
				end
				hsx_pkg::PH_LEE: begin
					res.list = hsx_pkg::push(res.list, 4'h1);
					res.list = hsx_pkg::push(res.list, 4'hE);
					res.list = hsx_pkg::push(res.list, 4'hE);
				end
				default: res.list = res.list;
			endcase
			res.phase = hsx_pkg::PH_IDLE;
		end
	end

endmodule

// ===== hw/rtl/hsx_collect.sv =====
module hsx_collect (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   char_byte,
	input  logic         last_byte,
	input  logic [5:0]   cap,
	output logic [127:0] shift_nxt,
	output logic [5:0]   count_nxt
);

	hsx_pkg::phase_t    phase_q;
	logic [127:0]       shift_q;
	logic [5:0]         count_q;
	hsx_pkg::scan_res_t res;
	logic [5:0]         room;
	logic [2:0]         take;
	logic [2:0]         skip;
	logic [15:0]        picked;

	hsx_decode u_decode (
		.phase     (phase_q),
		.char_byte (char_byte),
		.last_byte (last_byte),
		.count     (count_q),
		.cap       (cap),
		.res       (res)
	);

	assign room = (count_q < cap) ? cap - count_q : 6'd0;

	// Nibbles beyond the free room are dropped from the tail of the list.
	always_comb begin
		if ({3'b000, res.list.cnt} <= room) begin
			take = res.list.cnt;
		end else begin
			take = room[2:0];
		end
		skip   = res.list.cnt - take;
		picked = res.list.nibs >> {skip, 2'b00};
		case (take)
			3'd1:    shift_nxt = {shift_q[123:0], picked[3:0]};
			3'd2:    shift_nxt = {shift_q[119:0], picked[7:0]};
			3'd3:    shift_nxt = {shift_q[115:0], picked[11:0]};
			3'd4:    shift_nxt = {shift_q[111:0], picked[15:0]};
			default: shift_nxt = shift_q;
		endcase
		count_nxt = count_q + {3'b000, take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hsx_pkg::PH_IDLE;
			shift_q <= '0;
			count_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q <= hsx_pkg::PH_IDLE;
				shift_q <= '0;
				count_q <= '0;
			end else begin
				phase_q <= res.phase;
				shift_q <= shift_nxt;
				count_q <= count_nxt;
			end
		end
	end

endmodule

// ===== hw/rtl/hsx_merge.sv =====
module hsx_merge (
	input  logic [63:0]  base_high,
	input  logic [63:0]  base_low,
	input  logic [127:0] shift,
	input  logic [5:0]   count,
	input  logic [5:0]   cap,
	output logic [127:0] addr,
	output logic [5:0]   total
);

	logic [127:0] mask;

	always_comb begin
		for (int j = 0; j < hsx_pkg::NIB_SLOTS; j++) begin
			mask[4*j +: 4] = (6'(j) < cap) ? 4'hF : 4'h0;
		end
		addr  = ({base_high, base_low} & ~mask) | (shift & mask);
		total = (count < cap) ? count : cap;
	end

endmodule

// ===== hw/rtl/hexspeak_address_suffix_unit.sv =====
// Turns a host name, fed one UTF-8 byte per item, into an IPv6 address whose low
// suffix bytes spell the name in hex by leetspeak rules; one address item comes out
// for every byte marked last_byte. The unit takes one byte every cycle. A byte sits
// in the input register while the scan stage decodes it and updates the nibble
// collector, and the address of a name is registered in the result register when its
// last byte leaves the scan stage. The input holds back only while a finished address
// waits on out_ready and the next last byte is ready to produce another. Write
// configuration only while no name is in progress.
module hexspeak_address_suffix_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low,
	output logic [5:0]  nibble_total
);

	logic [63:0]  base_high_q;
	logic [63:0]  base_low_q;
	logic [3:0]   prefix_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         out_valid_q;
	logic [127:0] addr_q;
	logic [5:0]   total_q;
	logic         out_free;
	logic         advance;
	logic [5:0]   cap;
	logic [127:0] shift_nxt;
	logic [5:0]   count_nxt;
	logic [127:0] addr_nxt;
	logic [5:0]   total_nxt;

	assign cap      = hsx_pkg::suffix_cap(prefix_q);
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_high_q <= '0;
			base_low_q  <= '0;
			prefix_q    <= hsx_pkg::PREFIX_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				hsx_pkg::REG_BASE_HIGH: base_high_q <= cfg_data;
				hsx_pkg::REG_BASE_LOW:  base_low_q  <= cfg_data;
				hsx_pkg::REG_PREFIX:    prefix_q    <= cfg_data[3:0];
				default:                prefix_q    <= prefix_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= char_byte;
			last_s1 <= last_byte;
		end
	end

	hsx_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_byte (byte_s1),
		.last_byte (last_s1),
		.cap       (cap),
		.shift_nxt (shift_nxt),
		.count_nxt (count_nxt)
	);

	hsx_merge u_merge (
		.base_high (base_high_q),
		.base_low  (base_low_q),
		.shift     (shift_nxt),
		.count     (count_nxt),
		.cap       (cap),
		.addr      (addr_nxt),
		.total     (total_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			addr_q  <= addr_nxt;
			total_q <= total_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign addr_high    = addr_q[127:64];
	assign addr_low     = addr_q[63:0];
	assign nibble_total = total_q;

	// A finished name always lands in the result register on the next edge.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid)
		else $error("last byte retired without a result");

	// A result only appears after a last byte left the scan stage.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && last_s1))
		else $error("result without a last byte");

	// The scan stage never retires a last byte over an unread result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 && out_valid_q |-> out_ready)
		else $error("pending result overwritten");

	// Reported nibble count never exceeds the suffix capacity.
	a_total_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nibble_total <= cap)
		else $error("nibble total above suffix capacity");

endmodule
